// ----- hw/rtl/bsa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_pkg: shared types and constants of the bitmap slot allocator
// Opcodes, controller states, the command and status bundles between the
// controller and the datapath, and the field widths of the ports.
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int OPC_W             = 2;
  localparam int IDX_W             = 12;
  localparam int CNT_W             = 13;
  localparam int CFG_ADDR_W        = 3;
  localparam int CFG_DATA_W        = 32;
  localparam int BYTE_W            = 8;
  localparam int CAPACITY_BITS_DEF = 4096;

  localparam logic [CNT_W-1:0]  BIT_COUNT_RST = 13'd4096;
  localparam logic [BYTE_W-1:0] BIT_MSB       = 8'h80;

  // register select: paddr[2] picks the register
  localparam logic CFG_SEL_BIT_COUNT = 1'b0;

  typedef enum logic [OPC_W-1:0] {
    OP_FIND  = 2'd0,
    OP_GET   = 2'd1,
    OP_SET   = 2'd2,
    OP_UNSET = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_ERR
  } state_t;

  typedef enum logic [1:0] {
    RES_ERR,
    RES_ACC,
    RES_FIND
  } res_sel_t;

  typedef struct packed {
    logic     load;
    logic     rd_en;
    logic     wr_bit;
    logic     clr_wr;
    logic     adv;
    logic     res_load;
    res_sel_t res_sel;
  } cmd_t;

  typedef struct packed {
    logic    in_range;
    opcode_t op;
    logic    hit;
    logic    last_byte;
    logic    clr_last;
  } stat_t;

endpackage

// ----- hw/rtl/bsa_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_ram: generic single-clock RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bsa_ram #(
  parameter int WIDTH = bsa_pkg::BYTE_W,
  parameter int DEPTH = (bsa_pkg::CAPACITY_BITS_DEF + 7) / 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/bsa_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_datapath: scan pointer, byte evaluation and result registers
// Holds the bit store, the request latch and the clear sweep counter.
// ----------------------------------------------------------------------------
module bsa_datapath #(
  parameter int CAPACITY_BITS = bsa_pkg::CAPACITY_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bsa_pkg::cmd_t               cmd,
  output bsa_pkg::stat_t              stat,
  input  logic [bsa_pkg::CNT_W-1:0]   bit_count,
  input  logic [bsa_pkg::OPC_W-1:0]   in_opcode,
  input  logic [bsa_pkg::IDX_W-1:0]   in_bit_index,
  output logic                        out_old_bit,
  output logic [bsa_pkg::IDX_W-1:0]   out_found_index,
  output logic                        out_status
);

  localparam int StoreBytes = (CAPACITY_BITS + 7) / 8;
  localparam int AddrW      = (StoreBytes > 1) ? $clog2(StoreBytes) : 1;
  localparam int CntW       = bsa_pkg::CNT_W;
  localparam int ByteW      = bsa_pkg::BYTE_W;
  localparam int CapClip    = (CAPACITY_BITS > 8191) ? 8191 : CAPACITY_BITS;

  logic [CntW-1:0]       count_eff;
  logic [CntW-1:0]       scan_r;
  bsa_pkg::opcode_t      op_r;
  logic [AddrW-1:0]      clr_addr_r;
  logic                  old_bit_r;
  logic [bsa_pkg::IDX_W-1:0] found_r;
  logic                  status_r;

  logic [CntW-4:0]       byte_idx;
  logic [AddrW-1:0]      byte_addr;
  logic [CntW:0]         next_base;
  logic [ByteW-1:0]      rd_data;
  logic [ByteW-1:0]      bit_mask;
  logic                  acc_bit;
  logic [ByteW-1:0]      wr_byte;
  logic [ByteW-1:0]      zero_vec;
  logic [2:0]            hit_pos;
  logic                  ram_wr_en;
  logic [AddrW-1:0]      ram_wr_addr;
  logic [ByteW-1:0]      ram_wr_data;

  assign count_eff = (bit_count > CntW'(CapClip)) ? CntW'(CapClip) : bit_count;

  assign byte_idx  = scan_r[CntW-1:3];
  assign byte_addr = AddrW'(byte_idx);
  assign next_base = {1'b0, byte_idx, 3'b000} + (CntW+1)'(8);

  // bit access for get, set and unset
  assign bit_mask = bsa_pkg::BIT_MSB >> scan_r[2:0];
  assign acc_bit  = |(rd_data & bit_mask);
  assign wr_byte  = (op_r == bsa_pkg::OP_SET) ? (rd_data | bit_mask) : (rd_data & ~bit_mask);

  // clear bits of the current byte that lie in [scan, count)
  always_comb begin
    logic [CntW-1:0] cand;
    cand     = '0;
    zero_vec = '0;
    hit_pos  = '0;
    for (int p = 0; p < ByteW; p++) begin
      cand        = {byte_idx, 3'(p)};
      zero_vec[p] = !rd_data[3'(ByteW - 1 - p)] && (3'(p) >= scan_r[2:0]) && (cand < count_eff);
    end
    for (int p = ByteW - 1; p >= 0; p--) begin
      if (zero_vec[p]) begin
        hit_pos = 3'(p);
      end
    end
  end

  assign stat.in_range  = ({1'b0, in_bit_index} < count_eff);
  assign stat.op        = op_r;
  assign stat.hit       = |zero_vec;
  assign stat.last_byte = (next_base >= {1'b0, count_eff});
  assign stat.clr_last  = (clr_addr_r == AddrW'(StoreBytes - 1));

  assign ram_wr_en   = cmd.clr_wr | cmd.wr_bit;
  assign ram_wr_addr = cmd.clr_wr ? clr_addr_r : byte_addr;
  assign ram_wr_data = cmd.clr_wr ? '0 : wr_byte;

  bsa_ram #(
    .WIDTH (ByteW),
    .DEPTH (StoreBytes)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (byte_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr_r <= clr_addr_r + AddrW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_r <= {1'b0, in_bit_index};
      op_r   <= bsa_pkg::opcode_t'(in_opcode);
    end else if (cmd.adv) begin
      scan_r <= next_base[CntW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_sel)
        bsa_pkg::RES_ACC: begin
          old_bit_r <= acc_bit;
          found_r   <= '0;
          status_r  <= 1'b0;
        end
        bsa_pkg::RES_FIND: begin
          old_bit_r <= 1'b0;
          found_r   <= bsa_pkg::IDX_W'({byte_idx, hit_pos});
          status_r  <= 1'b0;
        end
        default: begin
          old_bit_r <= 1'b0;
          found_r   <= '0;
          status_r  <= 1'b1;
        end
      endcase
    end
  end

  assign out_old_bit     = old_bit_r;
  assign out_found_index = found_r;
  assign out_status      = status_r;

endmodule

// ----- hw/rtl/bsa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_ctrl: sequencing state machine
// Runs the clear sweep, takes requests, steps the byte scan and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module bsa_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  bsa_pkg::stat_t  stat,
  output bsa_pkg::cmd_t   cmd
);

  bsa_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != bsa_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsa_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.res_sel = bsa_pkg::RES_ERR;
    unique case (state_r)
      bsa_pkg::ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = bsa_pkg::ST_IDLE;
        end
      end
      bsa_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = stat.in_range ? bsa_pkg::ST_READ : bsa_pkg::ST_ERR;
        end
      end
      bsa_pkg::ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = bsa_pkg::ST_EVAL;
      end
      bsa_pkg::ST_EVAL: begin
        if (stat.op == bsa_pkg::OP_FIND) begin
          if (stat.hit) begin
            if (out_free) begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = bsa_pkg::RES_FIND;
              state_nxt    = bsa_pkg::ST_IDLE;
            end
          end else if (stat.last_byte) begin
            if (out_free) begin
              cmd.res_load = 1'b1;
              state_nxt    = bsa_pkg::ST_IDLE;
            end
          end else begin
            cmd.adv   = 1'b1;
            state_nxt = bsa_pkg::ST_READ;
          end
        end else if (out_free) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = bsa_pkg::RES_ACC;
          cmd.wr_bit   = (stat.op == bsa_pkg::OP_SET) || (stat.op == bsa_pkg::OP_UNSET);
          state_nxt    = bsa_pkg::ST_IDLE;
        end
      end
      bsa_pkg::ST_ERR: begin
        if (out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = bsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bsa_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hw/rtl/bitmap_slot_allocator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_top: bit store with find-first-clear
//
//   channel   direction  handshake               payload
//   in_       request    in_valid / in_stall     in_opcode, in_bit_index
//   out_      result     out_valid / out_stall   out_old_bit, out_found_index,
//                                                out_status
//   config    APB slave  psel/penable/pready     paddr, pwdata, prdata
//
// Get, set and unset pass through accept, RAM read and evaluate (set and
// unset write the byte back in the evaluate cycle). Find empty repeats the
// RAM read and the evaluate for each further byte scanned, since the
// single store RAM gives one byte per read.
// An out-of-range request goes from accept to the error state. After reset
// the store is swept to zero, one byte a cycle, (CAPACITY_BITS+7)/8 bytes
// (512 by default), with in_stall high; the register port works throughout.
// A waiting result does not block acceptance, only delivery of the next one.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_top #(
  parameter int CAPACITY_BITS = bsa_pkg::CAPACITY_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bsa_pkg::OPC_W-1:0]         in_opcode,
  input  logic [bsa_pkg::IDX_W-1:0]         in_bit_index,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_old_bit,
  output logic [bsa_pkg::IDX_W-1:0]         out_found_index,
  output logic                              out_status,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bsa_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [bsa_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [bsa_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

  bsa_pkg::cmd_t             cmd;
  bsa_pkg::stat_t            stat;
  logic [bsa_pkg::CNT_W-1:0] bit_count_r;
  logic                      cfg_wr;

  // Register port: single bit_count register, decoded on paddr[2].
  // Written at the access phase; always ready.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == bsa_pkg::CFG_SEL_BIT_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_count_r <= bsa_pkg::BIT_COUNT_RST;
    end else if (cfg_wr) begin
      bit_count_r <= pwdata[bsa_pkg::CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == bsa_pkg::CFG_SEL_BIT_COUNT) ?
                  bsa_pkg::CFG_DATA_W'(bit_count_r) : '0;

  // Controller: sequences the sweep, the read/evaluate loop and delivery.
  bsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: store RAM, scan pointer, byte evaluation, result registers.
  bsa_datapath #(
    .CAPACITY_BITS (CAPACITY_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .bit_count       (bit_count_r),
    .in_opcode       (in_opcode),
    .in_bit_index    (in_bit_index),
    .out_old_bit     (out_old_bit),
    .out_found_index (out_found_index),
    .out_status      (out_status)
  );

endmodule

// ----- verif/bitmap_slot_allocator_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_top_tb: self-checking bench for the bit store allocator
// Directed requests at the field and count extremes come from a table, then
// phases of random requests, each after a bit_count write. A bit store shadow
// predicts results not fixed in the table; the result channel is scored in order.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_top_tb;

  // Clock period in ns, and the number of cycles without any handshake that
  // ends the run. The slowest legal gap is a find that scans the whole store,
  // the sweep after reset or the long result hold below, all well under this
  // limit.
  localparam int CLK_PERIOD     = 4;
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int SINK_HOLD_CYC  = 300;
  localparam int TAIL_CYCLES    = 16;
  localparam int MAX_GAP        = 12;
  localparam int CAP            = bsa_pkg::CAPACITY_BITS_DEF;
  localparam int IDX_W          = bsa_pkg::IDX_W;
  localparam int CNT_W          = bsa_pkg::CNT_W;
  localparam int BYTE_W         = bsa_pkg::BYTE_W;
  localparam int OPC_W          = bsa_pkg::OPC_W;
  localparam int CFG_ADDR_W     = bsa_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W     = bsa_pkg::CFG_DATA_W;

  // register index; byte address is 4 times the index
  localparam int REG_BIT_COUNT = 0;

  typedef struct packed {
    logic             old_bit;
    logic [IDX_W-1:0] found_index;
    logic             status;
  } result_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [CNT_W-1:0]  cfg_value;
    bsa_pkg::opcode_t  op;
    logic [IDX_W-1:0]  idx;
    logic              fixed;
    result_t           want;
  } dir_row_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    int               items;
    logic             quiet;
    logic             hold;
  } phase_t;

  localparam result_t FAIL_RES = '{1'b0, 12'd0, 1'b1};
  localparam result_t OK_ZERO  = '{1'b0, 12'd0, 1'b0};
  localparam result_t OK_ONE   = '{1'b1, 12'd0, 1'b0};
  localparam result_t AT_TOP   = '{1'b0, 12'd4095, 1'b0};
  localparam result_t NONE_RES = '{1'b0, 12'd0, 1'b0};

  localparam int N_ROWS = 28;
  // Expected values are typed in only where they follow directly from reset,
  // the extremes or an error; rows with fixed = 0 go to the shadow model.
  localparam dir_row_t DIRECTED_ROWS [N_ROWS] = '{
    '{ROW_REQ, 13'd0,    bsa_pkg::OP_GET,   12'd0,    1'b1, OK_ZERO},   // fresh store
    '{ROW_REQ, 13'd0,    bsa_pkg::OP_GET,   12'd4095, 1'b1, OK_ZERO},
    '{ROW_REQ, 13'd0,    bsa_pkg::OP_FIND,  12'd0,    1'b1, OK_ZERO},
    '{ROW_REQ, 13'd0,    bsa_pkg::OP_FIND,  12'd4095, 1'b1, AT_TOP},
    '{ROW_REQ, 13'd0,    bsa_pkg::OP_SET,   12'd4095, 1'b1, OK_ZERO},
    '{ROW_REQ, 13'd0,    bsa_pkg::OP_SET,   12'd4095, 1'b1, OK_ONE},
    '{ROW_REQ, 13'd0,    bsa_pkg::OP_FIND,  12'd4095, 1'b1, FAIL_RES},  // nothing clear
    '{ROW_REQ, 13'd0,    bsa_pkg::OP_UNSET, 12'd4095, 1'b1, OK_ONE},
    '{ROW_REQ, 13'd0,    bsa_pkg::OP_UNSET, 12'd4095, 1'b0, NONE_RES},
    '{ROW_CFG, 13'd10,   bsa_pkg::OP_FIND,  12'd0,    1'b0, NONE_RES},  // partial byte
    '{ROW_REQ, 13'd0,    bsa_pkg::OP_SET,   12'd8,    1'b0, NONE_RES},
    '{ROW_REQ, 13'd0,    bsa_pkg::OP_SET,   12'd9,    1'b0, NONE_RES},
    '{ROW_REQ, 13'd0,    bsa_pkg::OP_GET,   12'd10,   1'b1, FAIL_RES},
    '{ROW_REQ, 13'd0,    bsa_pkg::OP_SET,   12'd10,   1'b1, FAIL_RES},
    '{ROW_REQ, 13'd0,    bsa_pkg::OP_FIND,  12'd10,   1'b1, FAIL_RES},
    '{ROW_REQ, 13'd0,    bsa_pkg::OP_FIND,  12'd8,    1'b1, FAIL_RES},  // bit 10 is past end
    '{ROW_REQ, 13'd0,    bsa_pkg::OP_FIND,  12'd0,    1'b1, OK_ZERO},
    '{ROW_CFG, 13'd0,    bsa_pkg::OP_FIND,  12'd0,    1'b0, NONE_RES},  // empty bitmap
    '{ROW_REQ, 13'd0,    bsa_pkg::OP_GET,   12'd0,    1'b1, FAIL_RES},
    '{ROW_REQ, 13'd0,    bsa_pkg::OP_FIND,  12'd0,    1'b1, FAIL_RES},
    '{ROW_REQ, 13'd0,    bsa_pkg::OP_UNSET, 12'd0,    1'b1, FAIL_RES},
    '{ROW_CFG, 13'd8191, bsa_pkg::OP_FIND,  12'd0,    1'b0, NONE_RES},  // saturates
    '{ROW_REQ, 13'd0,    bsa_pkg::OP_GET,   12'd4095, 1'b0, NONE_RES},
    '{ROW_REQ, 13'd0,    bsa_pkg::OP_FIND,  12'd4095, 1'b1, AT_TOP},
    '{ROW_REQ, 13'd0,    bsa_pkg::OP_GET,   12'd9,    1'b1, OK_ONE},    // kept across writes
    '{ROW_REQ, 13'd0,    bsa_pkg::OP_UNSET, 12'd9,    1'b0, NONE_RES},
    '{ROW_REQ, 13'd0,    bsa_pkg::OP_UNSET, 12'd8,    1'b0, NONE_RES},
    '{ROW_REQ, 13'd0,    bsa_pkg::OP_GET,   12'd8,    1'b1, OK_ZERO}
  };

  localparam int N_PHASES = 12;
  // One random phase per bit_count write; quiet phases run without idling,
  // the hold phase parks the result side while requests keep coming.
  localparam phase_t PHASES [N_PHASES] = '{
    '{13'd13,   110, 1'b0, 1'b0},
    '{13'd1,     60, 1'b0, 1'b0},
    '{13'd64,   150, 1'b1, 1'b1},
    '{13'd9,    110, 1'b0, 1'b0},
    '{13'd300,  150, 1'b0, 1'b0},
    '{13'd4096, 160, 1'b1, 1'b0},
    '{13'd8191, 130, 1'b0, 1'b0},
    '{13'd0,     40, 1'b0, 1'b0},
    '{13'd40,   130, 1'b0, 1'b0},
    '{13'd5000, 120, 1'b0, 1'b0},
    '{13'd2048, 130, 1'b0, 1'b0},
    '{13'd4096, 100, 1'b0, 1'b0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [OPC_W-1:0]      in_opcode;
  logic [IDX_W-1:0]      in_bit_index;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_old_bit;
  logic [IDX_W-1:0]      out_found_index;
  logic                  out_status;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // shadow of the block: byte store, bit count, and results still owed
  logic [BYTE_W-1:0] shadow_map [CAP/8];
  logic [CNT_W-1:0]  shadow_count;
  result_t           pending_results [$];

  int   mismatches;
  int   idle_cycles;
  logic quiet_phase;
  logic sink_hold;

  bitmap_slot_allocator_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_bit_index    (in_bit_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_old_bit     (out_old_bit),
    .out_found_index (out_found_index),
    .out_status      (out_status),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Work out the result of one accepted request and update the shadow store.
  function automatic result_t apply_request(bsa_pkg::opcode_t op, logic [IDX_W-1:0] idx);
    result_t           r;
    int                eff;
    int                i;
    logic [BYTE_W-1:0] mask;
    r    = FAIL_RES;
    eff  = (int'(shadow_count) > CAP) ? CAP : int'(shadow_count);
    mask = bsa_pkg::BIT_MSB >> idx[2:0];
    if (int'(idx) < eff) begin
      if (op == bsa_pkg::OP_FIND) begin
        // first clear bit at or after the start, never past the count
        i = int'(idx);
        while (i < eff && r.status) begin
          if (!shadow_map[i / 8][7 - (i % 8)]) begin
            r.found_index = IDX_W'(i);
            r.status      = 1'b0;
          end
          i++;
        end
      end else begin
        r.old_bit = |(shadow_map[idx[IDX_W-1:3]] & mask);
        r.status  = 1'b0;
        if (op == bsa_pkg::OP_SET)
          shadow_map[idx[IDX_W-1:3]] = shadow_map[idx[IDX_W-1:3]] | mask;
        else if (op == bsa_pkg::OP_UNSET)
          shadow_map[idx[IDX_W-1:3]] = shadow_map[idx[IDX_W-1:3]] & ~mask;
      end
    end
    return r;
  endfunction

  // Offer one request after a random gap (none in quiet phases) and hold it
  // until it is taken. Call at a rising edge; returns at the edge that accepts it.
  task automatic send_request(bsa_pkg::opcode_t op, logic [IDX_W-1:0] idx, logic fixed,
                              result_t want);
    int      gap;
    result_t r;
    gap = quiet_phase ? 0 : $urandom_range(MAX_GAP, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_bit_index <= idx;
    do @(posedge clk); while (in_stall);
    r = apply_request(op, idx);
    pending_results.push_back(fixed ? want : r);
  endtask

  // Drop valid and hold until every owed result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic report(string what, int want, int got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    mismatches++;
  endtask

  // Write bit_count through the register port, then read it back.
  task automatic write_bit_count(logic [CNT_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(4 * REG_BIT_COUNT);
    pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // the write lands at the edge above; go straight into the read setup
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata != CFG_DATA_W'(value))
      report("bit_count readback", int'(value), int'(prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    shadow_count = value;
  endtask

  // Result side: outside quiet phases, stall for a random number of cycles
  // after each result; on request, hold off for a long stretch so the block backs up.
  initial begin : result_sink
    int gap;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold) begin
        out_stall <= 1'b1;
        repeat (SINK_HOLD_CYC) @(posedge clk);
        sink_hold = 1'b0;
        out_stall <= 1'b0;
      end else if (out_valid && !out_stall) begin
        gap = quiet_phase ? 0 : $urandom_range(MAX_GAP, 0);
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Score each result against the oldest owed one.
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, old_bit %0d found_index %0d status %0d",
                 $time, out_old_bit, out_found_index, out_status);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_old_bit !== want.old_bit)
          report("old_bit", int'(want.old_bit), int'(out_old_bit));
        if (out_found_index !== want.found_index)
          report("found_index", int'(want.found_index), int'(out_found_index));
        if (out_status !== want.status)
          report("status", int'(want.status), int'(out_status));
      end
    end
  end

  // Abort if neither channel moves for too long.
  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("bitmap_slot_allocator_top_tb NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    int               p;
    int               sent;
    int               eff;
    int               pick;
    int               run_len;
    logic [IDX_W-1:0] base;
    logic [IDX_W-1:0] idx;
    bsa_pkg::opcode_t op;

    mismatches   = 0;
    idle_cycles  = 0;
    quiet_phase  = 1'b0;
    sink_hold    = 1'b0;
    shadow_count = bsa_pkg::BIT_COUNT_RST;
    foreach (shadow_map[i]) shadow_map[i] = '0;

    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_opcode    <= bsa_pkg::OP_FIND;
    in_bit_index <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed table; a register row waits for the block to go idle first
    foreach (DIRECTED_ROWS[r]) begin
      if (DIRECTED_ROWS[r].kind == ROW_CFG) begin
        wait_drained();
        write_bit_count(DIRECTED_ROWS[r].cfg_value);
      end else begin
        send_request(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].idx,
                     DIRECTED_ROWS[r].fixed, DIRECTED_ROWS[r].want);
      end
    end

    // random phases, each after a bit count write
    for (p = 0; p < N_PHASES; p++) begin
      wait_drained();
      write_bit_count(PHASES[p].count);
      quiet_phase = PHASES[p].quiet;
      if (PHASES[p].hold)
        sink_hold = 1'b1;
      eff  = (int'(shadow_count) > CAP) ? CAP : int'(shadow_count);
      sent = 0;
      while (sent < PHASES[p].items) begin
        pick = $urandom_range(99, 0);
        if (pick < 10 && eff > 0) begin
          // set a run of bits, then look for the first clear one from its
          // start, so the scan has to walk over full bytes
          base    = IDX_W'($urandom_range(eff - 1, 0));
          run_len = $urandom_range((eff > 512) ? 64 : 24, 4);
          for (int k = 0; k < run_len; k++)
            send_request(bsa_pkg::OP_SET, base + IDX_W'(k), 1'b0, NONE_RES);
          send_request(bsa_pkg::OP_FIND, base, 1'b0, NONE_RES);
          sent += run_len + 1;
        end else begin
          pick = $urandom_range(99, 0);
          if (pick < 35)      op = bsa_pkg::OP_SET;
          else if (pick < 50) op = bsa_pkg::OP_UNSET;
          else if (pick < 80) op = bsa_pkg::OP_FIND;
          else                op = bsa_pkg::OP_GET;
          if (eff > 0 && $urandom_range(99, 0) < 85)
            idx = IDX_W'($urandom_range(eff - 1, 0));
          else
            idx = IDX_W'($urandom_range((1 << IDX_W) - 1, 0));
          send_request(op, idx, 1'b0, NONE_RES);
          sent++;
        end
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("bitmap_slot_allocator_top_tb OK");
    else
      $display("bitmap_slot_allocator_top_tb NOT OK");
    $finish;
  end

endmodule
